FILE: design/cat_pkg.sv
package cat_pkg;

    localparam int SLOTS     = 16;
    localparam int KEY_BYTES = 16;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int SLOT_IN_W = 4;
    localparam int SEL_W     = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;
    localparam int KEY_W     = 64;
    localparam int PORT_W    = 16;

    typedef enum logic [1:0] {
        K_ADD     = 2'd0,
        K_RM_KEY  = 2'd1,
        K_RM_SLOT = 2'd2,
        K_LOOKUP  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FOUND     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CM_INSERT = 2'd0,
        CM_UPDATE = 2'd1,
        CM_CLEAR  = 2'd2
    } t_cop;

    // mask keeping the top n bytes of a 64-bit word
    function automatic logic [KEY_W-1:0] top_mask(input int n);
        logic [KEY_W-1:0] m;
        if (n <= 0) begin
            m = '0;
        end else if (n >= 8) begin
            m = '1;
        end else begin
            m = {KEY_W{1'b1}} << (KEY_W - 8 * n);
        end
        return m;
    endfunction

    localparam logic [KEY_W-1:0] HIGH_MASK = top_mask(KEY_BYTES);
    localparam logic [KEY_W-1:0] LOW_MASK  = top_mask(KEY_BYTES - 8);

    // search word passed from cell to cell
    typedef struct packed {
        logic                 valid;
        t_kind                kind;
        logic [KEY_W-1:0]     kh;
        logic [KEY_W-1:0]     kl;
        logic [PORT_W-1:0]    port;
        logic [SLOT_IN_W-1:0] slot;
        logic                 hit;
        logic [SLOT_W-1:0]    hit_idx;
        logic [PORT_W-1:0]    hit_port;
        logic                 free_ok;
        logic [SLOT_W-1:0]    free_idx;
    } t_probe;

    // write-back broadcast to all cells
    typedef struct packed {
        logic              en;
        t_cop              op;
        logic [SLOT_W-1:0] idx;
        logic [KEY_W-1:0]  kh;
        logic [KEY_W-1:0]  kl;
        logic [PORT_W-1:0] port;
    } t_commit;

endpackage

FILE: design/client_address_table.sv
// Client address table: a row of slots, each with a valid mark, a key and a port.
// Input channel: i_valid / o_stall with i_kind, i_key_high, i_key_low, i_port,
// i_slot. A word is taken at a clock edge with i_valid high and o_stall low.
// Kinds: add or update, remove by key, remove by slot, lookup.
// Output channel: o_valid / i_stall with o_status, o_slot_index, o_found_port;
// one result word per input word, in order.
// A search word walks the cell chain one slot per cycle, and the result is
// registered when the word leaves the last cell.
// The table write lands on the same edge that loads the result.
// The table takes no new word while a search word is in the chain. The next word
// may enter in the same cycle that the result appears, and is taken while that
// result waits, if the result is being taken or the output register is empty.
// A stalled result holds its value; o_stall stays high until it can drain.
// Reset (i_rst_n low, synchronous) empties every slot and drops any item in
// flight; stored keys and ports are not cleared and are never read before
// their slot is filled.
module client_address_table import cat_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_kind,
    input  logic [KEY_W-1:0]     i_key_high,
    input  logic [KEY_W-1:0]     i_key_low,
    input  logic [PORT_W-1:0]    i_port,
    input  logic [SLOT_IN_W-1:0] i_slot,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_status,
    output logic [3:0]           o_slot_index,
    output logic [PORT_W-1:0]    o_found_port
);

    t_probe  chain [0:SLOTS];
    t_commit commit;

    cat_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_key_high   (i_key_high),
        .i_key_low    (i_key_low),
        .i_port       (i_port),
        .i_slot       (i_slot),
        .o_head       (chain[0]),
        .i_tail       (chain[SLOTS]),
        .o_commit     (commit),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_found_port (o_found_port)
    );

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            cat_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cell_idx (SLOT_W'(g)),
                .i_probe    (chain[g]),
                .i_commit   (commit),
                .o_probe    (chain[g+1])
            );
        end
    endgenerate

endmodule

FILE: design/cat_cell.sv
module cat_cell import cat_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_cell_idx,
    input  t_probe            i_probe,
    input  t_commit           i_commit,
    output t_probe            o_probe
);

    logic              r_valid;
    logic [KEY_W-1:0]  r_kh;
    logic [KEY_W-1:0]  r_kl;
    logic [PORT_W-1:0] r_port;
    t_probe            r_probe;
    t_probe            n_probe;
    logic              key_hit;
    logic              slot_hit;
    logic              this_hit;
    logic              mine;

    assign key_hit  = r_valid && (r_kh == i_probe.kh) && (r_kl == i_probe.kl);
    assign slot_hit = r_valid && (SEL_W'(i_probe.slot) == SEL_W'(i_cell_idx));
    assign this_hit = (i_probe.kind == K_RM_SLOT) ? slot_hit : key_hit;
    assign mine     = i_commit.en && (i_commit.idx == i_cell_idx);

    always_comb begin
        n_probe = i_probe;
        // first hit along the chain wins
        if (i_probe.valid && !i_probe.hit && this_hit) begin
            n_probe.hit      = 1'b1;
            n_probe.hit_idx  = i_cell_idx;
            n_probe.hit_port = r_port;
        end
        if (i_probe.valid && !i_probe.free_ok && !r_valid) begin
            n_probe.free_ok  = 1'b1;
            n_probe.free_idx = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (mine) begin
                case (i_commit.op)
                    CM_INSERT: r_valid <= 1'b1;
                    CM_CLEAR:  r_valid <= 1'b0;
                    default:   r_valid <= r_valid;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mine) begin
            case (i_commit.op)
                CM_INSERT: begin
                    r_kh   <= i_commit.kh;
                    r_kl   <= i_commit.kl;
                    r_port <= i_commit.port;
                end
                CM_UPDATE: r_port <= i_commit.port;
                default: begin
                    r_port <= r_port;
                end
            endcase
        end
    end

    assign o_probe = r_probe;

endmodule

FILE: design/cat_ctrl.sv
module cat_ctrl import cat_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_kind,
    input  logic [KEY_W-1:0]     i_key_high,
    input  logic [KEY_W-1:0]     i_key_low,
    input  logic [PORT_W-1:0]    i_port,
    input  logic [SLOT_IN_W-1:0] i_slot,
    output t_probe               o_head,
    input  t_probe               i_tail,
    output t_commit              o_commit,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_status,
    output logic [3:0]           o_slot_index,
    output logic [PORT_W-1:0]    o_found_port
);

    logic              r_busy;
    logic              r_out_valid;
    t_status           r_status;
    logic [3:0]        r_idx;
    logic [PORT_W-1:0] r_port;
    t_status           n_status;
    logic [3:0]        n_idx;
    logic [PORT_W-1:0] n_port;
    t_commit           n_commit;
    logic              accept;
    logic              done;

    // take a word only when no scan is in flight and the output register is empty or being taken
    assign o_stall = r_busy || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign done    = i_tail.valid;

    always_comb begin
        o_head          = '0;
        o_head.valid    = accept;
        o_head.kind     = t_kind'(i_kind);
        o_head.kh       = i_key_high & HIGH_MASK;
        o_head.kl       = i_key_low & LOW_MASK;
        o_head.port     = i_port;
        o_head.slot     = i_slot;
    end

    always_comb begin
        n_status      = ST_NOT_FOUND;
        n_idx         = '0;
        n_port        = '0;
        n_commit      = '0;
        n_commit.op   = CM_CLEAR;
        n_commit.kh   = i_tail.kh;
        n_commit.kl   = i_tail.kl;
        n_commit.port = i_tail.port;
        case (i_tail.kind)
            K_ADD: begin
                if (i_tail.hit) begin
                    n_status     = ST_UPDATED;
                    n_idx        = 4'(i_tail.hit_idx);
                    n_commit.en  = done;
                    n_commit.op  = CM_UPDATE;
                    n_commit.idx = i_tail.hit_idx;
                end else if (i_tail.free_ok) begin
                    n_status     = ST_INSERTED;
                    n_idx        = 4'(i_tail.free_idx);
                    n_commit.en  = done;
                    n_commit.op  = CM_INSERT;
                    n_commit.idx = i_tail.free_idx;
                end else begin
                    n_status = ST_FULL;
                end
            end
            K_RM_KEY: begin
                if (i_tail.hit) begin
                    n_status     = ST_REMOVED;
                    n_idx        = 4'(i_tail.hit_idx);
                    n_commit.en  = done;
                    n_commit.idx = i_tail.hit_idx;
                end
            end
            K_RM_SLOT: begin
                n_idx = i_tail.slot;
                if (i_tail.hit) begin
                    n_status     = ST_REMOVED;
                    n_commit.en  = done;
                    n_commit.idx = i_tail.hit_idx;
                end
            end
            default: begin
                if (i_tail.hit) begin
                    n_status = ST_FOUND;
                    n_idx    = 4'(i_tail.hit_idx);
                    n_port   = i_tail.hit_port;
                end
            end
        endcase
    end

    assign o_commit = n_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_status <= n_status;
            r_idx    <= n_idx;
            r_port   <= n_port;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_idx;
    assign o_found_port = r_port;

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_busy)
        else $error("search word left the chain with no item in flight");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (!r_busy && r_out_valid))
        else $error("end of scan did not load the result");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && !r_out_valid))
        else $error("accepted word did not start a clean scan");

    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_commit.en |-> done)
        else $error("table write outside the end of a scan");

endmodule
